>>> src/b2da_pkg.sv
// Package for the binary to decimal ASCII converter.
// Holds shared widths, constants and item types, and the front end state type.
// No dependencies.
`timescale 1ns / 1ps

package b2da_pkg;

    // Field widths of the input and result items.
    localparam int VALUE_W = 63;
    localparam int MIN_W   = 6;
    localparam int CHAR_W  = 6;
    localparam int LEN_W   = 6;

    // Decimal digit storage and padding limit.
    localparam int VALUE_DIGITS = 19;
    localparam int MAX_PAD      = 32;
    localparam int DIG_W        = 4;
    localparam int NDIG_W       = $clog2(VALUE_DIGITS + 1);
    localparam int POS_W        = $clog2(MAX_PAD);
    localparam int CNT_W        = $clog2(VALUE_W);

    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(8'h30);
    localparam logic [DIG_W-1:0]  BCD_FIVE   = DIG_W'(5);
    localparam logic [DIG_W-1:0]  BCD_ADJ    = DIG_W'(3);

    // Queue between the converter and the character emitter.
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [MIN_W-1:0]   min_digits;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              is_last;
        logic [LEN_W-1:0]  total_length;
    } out_item_t;

    // One converted number waiting to be emitted.
    typedef struct packed {
        logic [VALUE_DIGITS-1:0][DIG_W-1:0] digits;
        logic [LEN_W-1:0]                   total;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_CONV,
        FR_DONE
    } front_state_t;

endpackage

>>> src/b2da_front.sv
// Front end: accepts an item and converts its value to BCD by shift-and-add-3.
// Computes the output length and hands the result to the queue.
// Depends on b2da_pkg.
`timescale 1ns / 1ps

module b2da_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_stall,
    input  b2da_pkg::in_item_t  src_data,
    output logic                push,
    output b2da_pkg::q_entry_t  push_entry,
    input  b2da_pkg::q_status_t q_status
);
    import b2da_pkg::*;

    front_state_t                       state_reg, state_next;
    logic [CNT_W-1:0]                   cnt_reg;
    logic [VALUE_W-1:0]                 bin_reg;
    logic [MIN_W-1:0]                   min_reg;
    logic [VALUE_DIGITS-1:0][DIG_W-1:0] bcd_reg;
    logic [VALUE_DIGITS-1:0][DIG_W-1:0] bcd_adj;
    logic [VALUE_DIGITS*DIG_W:0]        shift_word;
    logic [NDIG_W-1:0]                  ndig;
    logic [MIN_W-1:0]                   min_sat;
    logic [LEN_W-1:0]                   ndig_ext;
    logic                               load;
    logic                               step;

    // Add 3 to every digit of five or more, then shift in the next value bit.
    always_comb
    begin
        for (int i = 0; i < VALUE_DIGITS; i++)
        begin
            bcd_adj[i] = (bcd_reg[i] >= BCD_FIVE) ? bcd_reg[i] + BCD_ADJ : bcd_reg[i];
        end
        shift_word = {bcd_adj, bin_reg[VALUE_W-1]};
    end

    // Number of significant digits, at least one for a zero value.
    always_comb
    begin
        ndig = NDIG_W'(1);
        for (int i = 0; i < VALUE_DIGITS; i++)
        begin
            if (bcd_reg[i] != '0)
            begin
                ndig = NDIG_W'(i + 1);
            end
        end
    end

    // Saturate the requested minimum and take the larger of the two lengths.
    always_comb
    begin
        min_sat  = (min_reg > MIN_W'(MAX_PAD)) ? MIN_W'(MAX_PAD) : min_reg;
        ndig_ext = LEN_W'(ndig);
        push_entry.digits = bcd_reg;
        push_entry.total  = (LEN_W'(min_sat) > ndig_ext) ? LEN_W'(min_sat) : ndig_ext;
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and handshake outputs.
    always_comb
    begin
        state_next = state_reg;
        src_stall  = 1'b1;
        push       = 1'b0;
        load       = 1'b0;
        step       = 1'b0;
        unique case (state_reg)
            FR_IDLE:
            begin
                src_stall = 1'b0;
                if (src_valid)
                begin
                    load       = 1'b1;
                    state_next = FR_CONV;
                end
            end
            FR_CONV:
            begin
                step = 1'b1;
                if (cnt_reg == CNT_W'(VALUE_W - 1))
                begin
                    state_next = FR_DONE;
                end
            end
            FR_DONE:
            begin
                if (!q_status.full)
                begin
                    push       = 1'b1;
                    state_next = FR_IDLE;
                end
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase
    end

    // Bit counter for the conversion.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= '0;
        end
        else if (step)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    // Conversion datapath.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bin_reg <= src_data.value;
            min_reg <= src_data.min_digits;
            bcd_reg <= '0;
        end
        else if (step)
        begin
            bin_reg <= {bin_reg[VALUE_W-2:0], 1'b0};
            bcd_reg <= shift_word[VALUE_DIGITS*DIG_W-1:0];
        end
    end

endmodule

>>> src/b2da_queue.sv
// Short queue of converted numbers between the front end and the emitter.
// Flip-flop storage with read and write pointers and a fill count.
// Depends on b2da_pkg.
`timescale 1ns / 1ps

module b2da_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  b2da_pkg::q_entry_t  push_entry,
    input  logic                pop,
    output b2da_pkg::q_entry_t  head,
    output b2da_pkg::q_status_t status
);
    import b2da_pkg::*;

    q_entry_t          entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign head             = entry_reg[rd_ptr_reg];
    assign status.full      = (count_reg == QCNT_W'(QDEPTH));
    assign status.not_empty = (count_reg != '0);

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> src/b2da_back.sv
// Back end: emits the queued number one ASCII character per item.
// Leading padding falls out of reading digits above the significant ones.
// Depends on b2da_pkg.
`timescale 1ns / 1ps

module b2da_back (
    input  logic                clk,
    input  logic                rst_n,
    input  b2da_pkg::q_entry_t  head,
    input  b2da_pkg::q_status_t q_status,
    output logic                pop,
    output logic                res_valid,
    input  logic                res_stall,
    output b2da_pkg::out_item_t res_data
);
    import b2da_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic             out_valid_reg;
    out_item_t        out_data_reg;
    logic [LEN_W-1:0] idx_full;
    logic [POS_W-1:0] idx;
    logic [DIG_W-1:0] dsel;
    logic             last;
    logic             load;

    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

    // Digit index counted from the least significant end.
    always_comb
    begin
        idx_full = head.total - LEN_W'(1) - LEN_W'(pos_reg);
        idx      = idx_full[POS_W-1:0];
        last     = (idx == '0);
        load     = q_status.not_empty && (!out_valid_reg || !res_stall);
        pop      = load && last;
    end

    // Digit select; positions above the stored digits read as zero.
    always_comb
    begin
        dsel = '0;
        for (int i = 0; i < VALUE_DIGITS; i++)
        begin
            if (idx == POS_W'(i))
            begin
                dsel = head.digits[i];
            end
        end
    end

    // Output register and character position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                pos_reg       <= last ? '0 : pos_reg + POS_W'(1);
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg.digit_char   <= ASCII_ZERO + CHAR_W'(dsel);
            out_data_reg.is_last      <= last;
            out_data_reg.total_length <= head.total;
        end
    end

endmodule

>>> src/binary_to_decimal_ascii.sv
// Binary to decimal ASCII converter, top level.
// The converter takes one item at a time, converting one value bit per cycle;
// results wait in the queue, and the emitter gives one character per cycle
// while res_stall is low.
// Reset: asynchronous, active low; clears the queue and all handshake state.
`timescale 1ns / 1ps

module binary_to_decimal_ascii (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_stall,
    input  b2da_pkg::in_item_t  src_data,
    output logic                res_valid,
    input  logic                res_stall,
    output b2da_pkg::out_item_t res_data
);
    import b2da_pkg::*;

    logic      push;
    logic      pop;
    q_entry_t  push_entry;
    q_entry_t  head;
    q_status_t q_status;

    // Converter.
    b2da_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .src_data   (src_data),
        .push       (push),
        .push_entry (push_entry),
        .q_status   (q_status)
    );

    // Queue of converted numbers.
    b2da_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    // Character emitter.
    b2da_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule

>>> src/b2da_chk.sv
// Port-level checks for the binary to decimal ASCII converter.
// Bound to the top level; depends on b2da_pkg.
`timescale 1ns / 1ps

module b2da_chk (
    input logic                clk,
    input logic                rst_n,
    input logic                src_valid,
    input logic                src_stall,
    input logic                res_valid,
    input logic                res_stall,
    input b2da_pkg::out_item_t res_data
);
    import b2da_pkg::*;

    logic [LEN_W-1:0] seen_reg;
    logic             res_acc;

    assign res_acc = res_valid && !res_stall;

    // Characters already delivered for the current number.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else if (res_acc)
        begin
            seen_reg <= res_data.is_last ? '0 : seen_reg + LEN_W'(1);
        end
    end

    // A stalled result item stays offered.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result item withdrawn while stalled");

    // The converter takes one item at a time.
    a_src_busy: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && !src_stall |=> src_stall)
        else $error("input accepted while a conversion runs");

    // Characters are decimal digits and lengths stay in range.
    a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.digit_char >= ASCII_ZERO)
                   && (res_data.digit_char <= ASCII_ZERO + CHAR_W'(9))
                   && (res_data.total_length != '0)
                   && (res_data.total_length <= LEN_W'(MAX_PAD)))
        else $error("result item out of range");

    // The last character arrives exactly at the announced length.
    a_res_len: assert property (@(posedge clk) disable iff (!rst_n)
        res_acc |-> (res_data.is_last == (seen_reg + LEN_W'(1) == res_data.total_length)))
        else $error("last flag disagrees with total length");

endmodule

bind binary_to_decimal_ascii b2da_chk u_chk (.*);
